// File: hdl/mevmidi_pkg.sv
// Shared types, codes and constants of the melody event to MIDI converter.
`default_nettype none
package mevmidi_pkg;

   localparam int NOTE_STORE_DEPTH_DEF = 6;
   localparam int MIDI_CHANNELS_DEF    = 16;

   localparam int MSG_MAX   = 9;
   localparam int MSG_LEN_W = 4;

   // event kinds
   localparam logic [1:0] CMD_NOTE   = 2'd0;
   localparam logic [1:0] CMD_TYPEB  = 2'd1;
   localparam logic [1:0] CLASS_CTRL = 2'd3;

   // type B identifiers
   localparam logic [7:0] EID_MVOL     = 8'hB0;
   localparam logic [3:0] EID_TEMPO_HI = 4'hC;
   localparam logic [7:0] EID_EOT      = 8'hDF;
   localparam logic [7:0] EID_PROG     = 8'hE0;
   localparam logic [7:0] EID_BANK     = 8'hE1;
   localparam logic [7:0] EID_VOL      = 8'hE2;
   localparam logic [7:0] EID_PAN      = 8'hE3;
   localparam logic [7:0] EID_BEND     = 8'hE4;
   localparam logic [7:0] EID_MOD      = 8'hEA;

   localparam logic [6:0]  KEY_BASE       = 7'd45;
   localparam logic [7:0]  NOTE_OFF_VEL   = 8'd64;
   localparam logic [25:0] TEMPO_DIVIDEND = 26'd60000000;
   localparam logic [23:0] TEMPO_MAX      = 24'hFFFFFF;
   localparam logic [27:0] DELTA_MAX      = 28'hFFFFFFF;

   // register indexes
   localparam logic REG_CHANNEL_OFFSET = 1'b0;

   typedef struct packed {
      logic [1:0] cmd;
      logic       track_start;
      logic [7:0] delta_time;
      logic [1:0] channel;
      logic [5:0] note_key;
      logic [7:0] gate_time;
      logic [5:0] velocity;
      logic [1:0] octave_shift;
      logic [7:0] event_id;
      logic [7:0] event_data;
   } req_type;

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       last;
      logic       note_dropped;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic scan_start;
      logic scan_step;
      logic off_prep;
      logic ev_prep;
      logic emit_delta;
      logic emit_msg;
      logic remove;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic div_busy;
      logic emit;
      logic push_ok;
      logic delta_last;
      logic msg_last;
      logic hold_empty;
   } ctl_sts_type;

endpackage
`default_nettype wire

// File: hdl/mevmidi_ctrl.sv
// Sequencer for the converter: scan, note-off emission and event emission.
`default_nettype none
module mevmidi_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire mevmidi_pkg::ctl_sts_type  sts,
   output mevmidi_pkg::ctl_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ADV   = 4'd1;
   localparam logic [3:0] S_SCAN0 = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_OFFP  = 4'd4;
   localparam logic [3:0] S_DELTA = 4'd5;
   localparam logic [3:0] S_MSG   = 4'd6;
   localparam logic [3:0] S_REM   = 4'd7;
   localparam logic [3:0] S_WAIT  = 4'd8;
   localparam logic [3:0] S_EVP   = 4'd9;
   localparam logic [3:0] S_EVC   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       off_ff, off_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      off_in   = off_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            state_in    = S_SCAN0;
         end
         S_SCAN0: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = sts.found ? S_OFFP : S_WAIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_OFFP: begin
            cmd.off_prep = 1'b1;
            off_in       = 1'b1;
            state_in     = S_DELTA;
         end
         S_DELTA: begin
            cmd.emit_delta = 1'b1;
            if (sts.push_ok && sts.delta_last) state_in = S_MSG;
         end
         S_MSG: begin
            cmd.emit_msg = 1'b1;
            if (sts.push_ok && sts.msg_last) state_in = off_ff ? S_REM : S_FIN;
         end
         S_REM: begin
            cmd.remove = 1'b1;
            state_in   = S_SCAN0;
         end
         S_WAIT: begin
            if (!sts.div_busy) state_in = S_EVP;
         end
         S_EVP: begin
            cmd.ev_prep = 1'b1;
            off_in      = 1'b0;
            state_in    = S_EVC;
         end
         S_EVC: begin
            state_in = sts.emit ? S_DELTA : S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            if (sts.push_ok) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         off_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         off_ff   <= off_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> sts.hold_empty)
      else $error("byte left in hold while idle");
   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && sts.push_ok) |=> state_ff == S_IDLE)
      else $error("finish did not return to idle");
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= S_FIN)
      else $error("sequencer in an unknown state");
`endif

endmodule
`default_nettype wire

// File: hdl/mevmidi_dp.sv
// Datapath: time and delta state, note store, bank store, tempo divider, byte output.
`default_nettype none
module mevmidi_dp #(
   parameter int NOTE_STORE_DEPTH = mevmidi_pkg::NOTE_STORE_DEPTH_DEF,
   parameter int MIDI_CHANNELS    = mevmidi_pkg::MIDI_CHANNELS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mevmidi_pkg::req_type      req_data,
   input  wire logic [3:0]                chan_offset,
   input  wire mevmidi_pkg::ctl_cmd_type  cmd,
   output mevmidi_pkg::ctl_sts_type       sts,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output mevmidi_pkg::rsp_type           rsp_data
);

   localparam int CNTW = $clog2(NOTE_STORE_DEPTH + 1);
   localparam int IDXW = (NOTE_STORE_DEPTH > 1) ? $clog2(NOTE_STORE_DEPTH) : 1;
   localparam int CHW  = $clog2(MIDI_CHANNELS);

   mevmidi_pkg::req_type item_ff;

   logic [31:0] abs_ff;
   logic [27:0] pend_ff;
   logic [5:0]  bank_ff [MIDI_CHANNELS];
   logic [3:0]  pn_chan_ff [NOTE_STORE_DEPTH];
   logic [6:0]  pn_key_ff  [NOTE_STORE_DEPTH];
   logic [31:0] pn_gate_ff [NOTE_STORE_DEPTH];
   logic [CNTW-1:0] count_ff;

   logic [CNTW-1:0] idx_ff;
   logic [IDXW-1:0] best_ff;
   logic            found_ff;
   logic [31:0]     best_gate_ff;
   logic [3:0]      best_chan_ff;
   logic [6:0]      best_key_ff;

   logic [27:0]          dv_ff;
   logic [7:0]           msg_ff [mevmidi_pkg::MSG_MAX];
   logic [mevmidi_pkg::MSG_LEN_W-1:0] len_ff, pos_ff;
   logic [1:0]           grp_ff;
   logic                 emit_ff;
   logic                 dropped_ff;

   logic        busy_ff;
   logic [4:0]  dcnt_ff;
   logic [7:0]  rem_ff;
   logic [25:0] quo_ff;

   logic        hold_v_ff, out_v_ff;
   logic [7:0]  hold_byte_ff;
   logic        hold_drop_ff;
   mevmidi_pkg::rsp_type out_ff;

   // event decode
   logic        is_ctrl, is_tempo, is_note;
   logic [3:0]  mch, dch;
   logic [5:0]  low6;
   logic        dch_ok;
   logic [5:0]  bank_rd;
   logic [6:0]  key;
   logic [23:0] tempo;

   assign is_note  = (item_ff.cmd == mevmidi_pkg::CMD_NOTE);
   assign is_ctrl  = (item_ff.cmd == mevmidi_pkg::CMD_TYPEB) &&
                     (item_ff.channel == mevmidi_pkg::CLASS_CTRL);
   assign is_tempo = is_ctrl &&
                     (item_ff.event_id[7:4] == mevmidi_pkg::EID_TEMPO_HI);
   assign mch    = chan_offset + {2'b00, item_ff.channel};
   assign dch    = chan_offset + {2'b00, item_ff.event_data[7:6]};
   assign low6   = item_ff.event_data[5:0];
   assign dch_ok = ({1'b0, dch} < 5'(MIDI_CHANNELS));
   assign bank_rd = dch_ok ? bank_ff[dch[CHW-1:0]] : 6'd0;
   assign tempo  = (item_ff.event_data == 8'd0 || quo_ff > 26'(mevmidi_pkg::TEMPO_MAX)) ?
                   mevmidi_pkg::TEMPO_MAX : quo_ff[23:0];

   always_comb begin
      key = {1'b0, item_ff.note_key} + mevmidi_pkg::KEY_BASE;
      case (item_ff.octave_shift)
         2'd1:    key = key + 7'd12;
         2'd2:    key = key - 7'd24;
         2'd3:    key = key - 7'd12;
         default: key = key;
      endcase
   end

   // event message build
   logic [7:0] ev_msg [mevmidi_pkg::MSG_MAX];
   logic [mevmidi_pkg::MSG_LEN_W-1:0] ev_len;
   logic       ev_emit;
   logic [5:0] bank_val;

   always_comb begin
      for (int i = 0; i < mevmidi_pkg::MSG_MAX; i++) ev_msg[i] = 8'h00;
      ev_len   = '0;
      ev_emit  = 1'b0;
      bank_val = low6;
      if (low6 == 6'd2 || low6 == 6'd3 || low6 == 6'h3F) bank_val = 6'd0;
      if (is_note) begin
         ev_emit = 1'b1; ev_len = 4'd3;
         ev_msg[0] = {4'h9, mch};
         ev_msg[1] = {1'b0, key};
         ev_msg[2] = {1'b0, item_ff.velocity, 1'b0};
      end else if (is_ctrl) begin
         if (item_ff.event_id == mevmidi_pkg::EID_MVOL) begin
            ev_emit = 1'b1; ev_len = 4'd9;
            ev_msg[0] = 8'hF0; ev_msg[1] = 8'h07; ev_msg[2] = 8'h7F;
            ev_msg[3] = 8'h7F; ev_msg[4] = 8'h04; ev_msg[5] = 8'h01;
            ev_msg[6] = 8'h00; ev_msg[7] = item_ff.event_data; ev_msg[8] = 8'hF7;
         end else if (item_ff.event_id[7:4] == mevmidi_pkg::EID_TEMPO_HI) begin
            ev_emit = 1'b1; ev_len = 4'd6;
            ev_msg[0] = 8'hFF; ev_msg[1] = 8'h51; ev_msg[2] = 8'h03;
            ev_msg[3] = tempo[23:16]; ev_msg[4] = tempo[15:8]; ev_msg[5] = tempo[7:0];
         end else if (item_ff.event_id == mevmidi_pkg::EID_EOT) begin
            ev_emit = 1'b1; ev_len = 4'd3;
            ev_msg[0] = 8'hFF; ev_msg[1] = 8'h2F; ev_msg[2] = 8'h00;
         end else if (item_ff.event_id == mevmidi_pkg::EID_PROG) begin
            ev_emit = 1'b1; ev_len = 4'd2;
            ev_msg[0] = {4'hC, dch};
            ev_msg[1] = {1'b0, (bank_rd == 6'd3), low6};
         end else if (item_ff.event_id == mevmidi_pkg::EID_BANK) begin
            ev_emit = 1'b1; ev_len = 4'd3;
            ev_msg[0] = {4'hB, dch}; ev_msg[1] = 8'h00; ev_msg[2] = {2'b00, bank_val};
         end else if (item_ff.event_id == mevmidi_pkg::EID_VOL) begin
            ev_emit = 1'b1; ev_len = 4'd3;
            ev_msg[0] = {4'hB, dch}; ev_msg[1] = 8'h07; ev_msg[2] = {1'b0, low6, 1'b0};
         end else if (item_ff.event_id == mevmidi_pkg::EID_PAN) begin
            ev_emit = 1'b1; ev_len = 4'd3;
            ev_msg[0] = {4'hB, dch}; ev_msg[1] = 8'h0A; ev_msg[2] = {1'b0, low6, 1'b0};
         end else if (item_ff.event_id == mevmidi_pkg::EID_BEND) begin
            ev_emit = 1'b1; ev_len = 4'd3;
            ev_msg[0] = {4'hE, dch}; ev_msg[1] = {1'b0, low6, 1'b0}; ev_msg[2] = 8'h00;
         end else if (item_ff.event_id == mevmidi_pkg::EID_MOD) begin
            ev_emit = 1'b1; ev_len = 4'd3;
            ev_msg[0] = {4'hB, dch}; ev_msg[1] = 8'h01; ev_msg[2] = {1'b0, low6, 1'b0};
         end
      end
   end

   // note-off timing
   logic [31:0] lag_full;
   logic [27:0] lag;
   assign lag_full = abs_ff - best_gate_ff;
   assign lag      = (lag_full > {4'h0, pend_ff}) ? pend_ff : lag_full[27:0];

   function automatic logic [1:0] groups_m1(input logic [27:0] v);
      logic [1:0] g;
      g = 2'd0;
      if (v >= 28'h80)     g = 2'd1;
      if (v >= 28'h4000)   g = 2'd2;
      if (v >= 28'h200000) g = 2'd3;
      return g;
   endfunction

   // advance sums, taken from the held request
   logic [31:0] abs_base;
   logic [28:0] pend_sum;
   assign abs_base = item_ff.track_start ? 32'd0 : abs_ff;
   assign pend_sum = (item_ff.track_start ? 29'd0 : {1'b0, pend_ff}) +
                     {21'd0, item_ff.delta_time};

   // scan entry
   logic [IDXW-1:0] sidx;
   logic            sdue;
   assign sidx = idx_ff[IDXW-1:0];
   assign sdue = (pn_gate_ff[sidx] <= abs_ff) &&
                 (!found_ff || pn_gate_ff[sidx] < best_gate_ff);

   // divider step
   logic [8:0] div_rs;
   assign div_rs = {rem_ff, mevmidi_pkg::TEMPO_DIVIDEND[dcnt_ff]};

   // byte output
   logic       out_free, push_ok, push, move;
   logic [7:0] delta_byte, push_byte;
   assign out_free = !out_v_ff || rsp_ready;
   assign push_ok  = !hold_v_ff || out_free;
   assign push     = (cmd.emit_delta || cmd.emit_msg) && push_ok;
   assign move     = hold_v_ff && out_free && (push || cmd.finish);

   always_comb begin
      case (grp_ff)
         2'd0:    delta_byte = {1'b0, dv_ff[6:0]};
         2'd1:    delta_byte = {1'b1, dv_ff[13:7]};
         2'd2:    delta_byte = {1'b1, dv_ff[20:14]};
         default: delta_byte = {1'b1, dv_ff[27:21]};
      endcase
   end
   assign push_byte = cmd.emit_delta ? delta_byte : msg_ff[pos_ff];

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;

      if (cmd.scan_step && sdue) begin
         best_ff      <= sidx;
         best_gate_ff <= pn_gate_ff[sidx];
         best_chan_ff <= pn_chan_ff[sidx];
         best_key_ff  <= pn_key_ff[sidx];
      end

      if (cmd.off_prep) begin
         dv_ff     <= pend_ff - lag;
         grp_ff    <= groups_m1(pend_ff - lag);
         pos_ff    <= '0;
         len_ff    <= 4'd3;
         msg_ff[0] <= {4'h8, best_chan_ff};
         msg_ff[1] <= {1'b0, best_key_ff};
         msg_ff[2] <= mevmidi_pkg::NOTE_OFF_VEL;
      end else if (cmd.ev_prep) begin
         dv_ff  <= pend_ff;
         grp_ff <= groups_m1(pend_ff);
         pos_ff <= '0;
         len_ff <= ev_len;
         for (int i = 0; i < mevmidi_pkg::MSG_MAX; i++) msg_ff[i] <= ev_msg[i];
      end else begin
         if (cmd.emit_delta && push_ok) grp_ff <= grp_ff - 2'd1;
         if (cmd.emit_msg && push_ok) pos_ff <= pos_ff + 4'd1;
      end

      if (cmd.ev_prep && is_note && count_ff < CNTW'(NOTE_STORE_DEPTH)) begin
         pn_chan_ff[count_ff[IDXW-1:0]] <= mch;
         pn_key_ff[count_ff[IDXW-1:0]]  <= key;
         pn_gate_ff[count_ff[IDXW-1:0]] <= abs_ff + {24'd0, item_ff.gate_time};
      end
      if (cmd.remove) begin
         for (int i = 0; i < NOTE_STORE_DEPTH - 1; i++) begin
            if (CNTW'(i) >= CNTW'(best_ff) && CNTW'(i + 1) < count_ff) begin
               pn_chan_ff[i] <= pn_chan_ff[i + 1];
               pn_key_ff[i]  <= pn_key_ff[i + 1];
               pn_gate_ff[i] <= pn_gate_ff[i + 1];
            end
         end
      end

      if (cmd.advance) begin
         dcnt_ff <= 5'd25;
         rem_ff  <= 8'd0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         dcnt_ff <= dcnt_ff - 5'd1;
         if (div_rs >= {1'b0, item_ff.event_data}) begin
            rem_ff <= 8'(div_rs - {1'b0, item_ff.event_data});
            quo_ff <= {quo_ff[24:0], 1'b1};
         end else begin
            rem_ff <= div_rs[7:0];
            quo_ff <= {quo_ff[24:0], 1'b0};
         end
      end

      if (push) begin
         hold_byte_ff <= push_byte;
         hold_drop_ff <= dropped_ff;
      end
      if (move) begin
         out_ff.midi_byte    <= hold_byte_ff;
         out_ff.note_dropped <= hold_drop_ff;
         out_ff.last         <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_ff     <= '0;
         pend_ff    <= '0;
         count_ff   <= '0;
         for (int i = 0; i < MIDI_CHANNELS; i++) bank_ff[i] <= '0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         emit_ff    <= 1'b0;
         dropped_ff <= 1'b0;
         busy_ff    <= 1'b0;
         hold_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         if (cmd.load) dropped_ff <= 1'b0;
         if (cmd.advance) begin
            abs_ff  <= abs_base + {24'd0, item_ff.delta_time};
            pend_ff <= pend_sum[28] ? mevmidi_pkg::DELTA_MAX : pend_sum[27:0];
            busy_ff <= is_tempo;
            if (item_ff.track_start) begin
               count_ff <= '0;
               for (int i = 0; i < MIDI_CHANNELS; i++) bank_ff[i] <= '0;
            end
         end else if (busy_ff && dcnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
         end
         if (cmd.scan_start) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + CNTW'(1);
            if (sdue) found_ff <= 1'b1;
         end
         if (cmd.off_prep) pend_ff <= lag;
         if (cmd.remove) count_ff <= count_ff - CNTW'(1);
         if (cmd.ev_prep) begin
            emit_ff <= ev_emit;
            if (ev_emit) pend_ff <= '0;
            if (is_note) begin
               if (count_ff < CNTW'(NOTE_STORE_DEPTH)) count_ff <= count_ff + CNTW'(1);
               else dropped_ff <= 1'b1;
            end
            if (is_ctrl && item_ff.event_id == mevmidi_pkg::EID_BANK && dch_ok)
               bank_ff[dch[CHW-1:0]] <= low6;
         end
         if (push) hold_v_ff <= 1'b1;
         else if (move) hold_v_ff <= 1'b0;
         if (move) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

   assign sts.scan_done  = (idx_ff == count_ff);
   assign sts.found      = found_ff;
   assign sts.div_busy   = busy_ff;
   assign sts.emit       = emit_ff;
   assign sts.push_ok    = push_ok;
   assign sts.delta_last = (grp_ff == 2'd0);
   assign sts.msg_last   = (pos_ff == len_ff - 4'd1);
   assign sts.hold_empty = !hold_v_ff;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(NOTE_STORE_DEPTH))
      else $error("note store count over depth");
   a_best_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.off_prep) |-> (found_ff && CNTW'(best_ff) < count_ff))
      else $error("note-off taken from an empty slot");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(dcnt_ff == 5'd0) || $past(cmd.advance))
      else $error("divider stopped early");
`endif

endmodule
`default_nettype wire

// File: hdl/melody_event_to_midi_converter_top.sv
// Top level of the melody event to MIDI track byte converter.
//
//   port group   role            handshake
//   req_*        event in        req_valid / req_ready
//   rsp_*        MIDI byte out   rsp_valid / rsp_ready
//   p* (APB)     channel_offset  psel, penable, pwrite, pready (always high)
//
// One request runs a gate-time scan over the stored notes, then emits its
// bytes; each note-off that falls due adds a rescan of the stored notes plus
// its bytes. A tempo event waits on a bit-serial divider that starts
// alongside the scan.
// Synchronous active-high reset clears time, delta, banks and the note store.
// A stalled rsp side holds one byte in the output register and one in the
// hold stage; further bytes stall the sequencer.
`default_nettype none
module melody_event_to_midi_converter_top #(
   parameter int NOTE_STORE_DEPTH = mevmidi_pkg::NOTE_STORE_DEPTH_DEF,
   parameter int MIDI_CHANNELS    = mevmidi_pkg::MIDI_CHANNELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire mevmidi_pkg::req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output mevmidi_pkg::rsp_type       rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   mevmidi_pkg::ctl_cmd_type cmd;
   mevmidi_pkg::ctl_sts_type sts;

   logic [3:0] chan_offset_ff;

   // register access: word 0 holds channel_offset
   assign pready = 1'b1;
   assign prdata = (paddr[2] == mevmidi_pkg::REG_CHANNEL_OFFSET) ?
                   {28'd0, chan_offset_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_offset_ff <= 4'd0;
      end else if (psel && penable && pwrite &&
                   paddr[2] == mevmidi_pkg::REG_CHANNEL_OFFSET) begin
         chan_offset_ff <= pwdata[3:0];
      end
   end

   mevmidi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mevmidi_dp #(
      .NOTE_STORE_DEPTH (NOTE_STORE_DEPTH),
      .MIDI_CHANNELS    (MIDI_CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .chan_offset (chan_offset_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
